>>> src/uue_pkg.sv
// ----------------------------------------------------------------------------
// uue_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder: the character
// record passed from the classifier to the byte serializer, and code ranges.
// ----------------------------------------------------------------------------
package uue_pkg;

  // code unit and character ranges
  localparam logic [15:0] SURR_LO    = 16'hD800;
  localparam logic [15:0] SURR_HI    = 16'hE000;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] ONE_BYTE   = 16'h0080;
  localparam logic [15:0] TWO_BYTE   = 16'h0800;

  // utf-8 lead and continuation marks
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // byte index codes (byte count minus one)
  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN3 = 2'd2;
  localparam logic [1:0] LEN4 = 2'd3;

  // record queue between classifier and serializer
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int TOTAL_W = 20;

  // one classified character or a bare end marker
  typedef struct packed {
    logic [20:0]        cp;        // code point
    logic [1:0]         last_idx;  // bytes minus one
    logic               emit;      // bytes are sent, else bare end marker
    logic               ends;      // string ends with this record
    logic [TOTAL_W-1:0] total;     // running byte count after the character
  } rec_t;

endpackage

>>> src/uue_front.sv
// ----------------------------------------------------------------------------
// uue_front
// Input classifier: holds surrogate, count and skip state, forms the code
// point and byte length of each character and decides what is emitted.
// ----------------------------------------------------------------------------
module uue_front #(
  parameter int LENGTH_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [15:0]         out_capacity,
  input  logic                in_fire,
  input  logic [15:0]         code_unit,
  input  logic                final_unit,
  output logic                rec_push,
  output uue_pkg::rec_t       rec
);

  localparam int CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;
  localparam logic [LENGTH_WIDTH-1:0] COUNT_MAX = '1;

  logic [15:0]             capacity;
  logic                    pending;
  logic [9:0]              high_bits;
  logic [LENGTH_WIDTH-1:0] count;
  logic                    skipping;

  logic                    pending_next;
  logic [9:0]              high_bits_next;
  logic [LENGTH_WIDTH-1:0] count_next;
  logic                    skipping_next;

  logic                    is_zero;
  logic                    is_surr;
  logic [20:0]             cp;
  logic [1:0]              last_idx;
  logic [LENGTH_WIDTH:0]   sum;
  logic [LENGTH_WIDTH-1:0] sat;
  logic                    fits;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 16'hFFFF;
    end else if (cfg_valid) begin
      capacity <= out_capacity;
    end
  end

  // code point and length of the character this unit completes
  always_comb begin
    is_zero = (code_unit == 16'd0);
    is_surr = (code_unit >= uue_pkg::SURR_LO) && (code_unit < uue_pkg::SURR_HI);
    if (pending) begin
      cp       = uue_pkg::SUPP_BASE + {1'b0, high_bits, code_unit[9:0]};
      last_idx = uue_pkg::LEN4;
    end else begin
      cp = {5'd0, code_unit};
      if (code_unit < uue_pkg::ONE_BYTE) begin
        last_idx = uue_pkg::LEN1;
      end else if (code_unit < uue_pkg::TWO_BYTE) begin
        last_idx = uue_pkg::LEN2;
      end else begin
        last_idx = uue_pkg::LEN3;
      end
    end
  end

  // saturating count and capacity check
  always_comb begin
    sum  = {1'b0, count} + (LENGTH_WIDTH+1)'({1'b0, last_idx} + 3'd1);
    sat  = sum[LENGTH_WIDTH] ? COUNT_MAX : sum[LENGTH_WIDTH-1:0];
    fits = CW'(sat) < CW'(capacity);
  end

  // next state and record
  always_comb begin
    pending_next   = pending;
    high_bits_next = high_bits;
    count_next     = count;
    skipping_next  = skipping;
    rec_push       = 1'b0;
    rec.cp         = cp;
    rec.last_idx   = last_idx;
    rec.emit       = 1'b0;
    rec.ends       = 1'b1;
    rec.total      = uue_pkg::TOTAL_W'(count);
    if (in_fire) begin
      if (skipping) begin
        if (final_unit) begin
          skipping_next = 1'b0;
        end
      end else if (!pending && is_zero) begin
        // terminator: bare end marker, then skip unless final
        rec_push      = 1'b1;
        count_next    = '0;
        skipping_next = !final_unit;
      end else if (!pending && is_surr) begin
        if (final_unit) begin
          // dangling high half is dropped
          rec_push   = 1'b1;
          count_next = '0;
        end else begin
          pending_next   = 1'b1;
          high_bits_next = code_unit[9:0];
        end
      end else begin
        // a full character
        rec.emit       = fits;
        rec.ends       = final_unit;
        rec.total      = uue_pkg::TOTAL_W'(sat);
        rec_push       = fits || final_unit;
        pending_next   = 1'b0;
        high_bits_next = '0;
        count_next     = final_unit ? '0 : sat;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      high_bits <= '0;
      count     <= '0;
      skipping  <= 1'b0;
    end else begin
      pending   <= pending_next;
      high_bits <= high_bits_next;
      count     <= count_next;
      skipping  <= skipping_next;
    end
  end

endmodule

>>> src/uue_queue.sv
// ----------------------------------------------------------------------------
// uue_queue
// Short record queue between classifier and serializer.
// ----------------------------------------------------------------------------
module uue_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  uue_pkg::rec_t wr_rec,
  input  logic          rd_en,
  output uue_pkg::rec_t rd_rec,
  output logic          rd_valid,
  output logic          q_full
);

  uue_pkg::rec_t             mem [uue_pkg::QDEPTH];
  logic [uue_pkg::QAW-1:0]   wr_ptr;
  logic [uue_pkg::QAW-1:0]   rd_ptr;
  logic [uue_pkg::QAW:0]     fill;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (uue_pkg::QAW+1)'(wr_en) - (uue_pkg::QAW+1)'(rd_en);
    end
  end

  assign rd_rec   = mem[rd_ptr];
  assign rd_valid = (fill != '0);
  assign q_full   = (fill == (uue_pkg::QAW+1)'(uue_pkg::QDEPTH));

endmodule

>>> src/uue_back.sv
// ----------------------------------------------------------------------------
// uue_back
// Byte serializer: walks the head record into an output register that the
// receiver drains, one UTF-8 byte per cycle while it is free or popped.
// ----------------------------------------------------------------------------
module uue_back (
  input  logic          clk,
  input  logic          rst,
  input  uue_pkg::rec_t head,
  input  logic          head_valid,
  output logic          head_done,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          run_last,
  output logic          string_end,
  output logic [19:0]   total_length
);

  logic       obuf_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] b0, b1, b2, b3;
  logic [7:0] sel_byte;

  // byte image of the head character
  always_comb begin
    b0 = {1'b0, head.cp[6:0]};
    b1 = 8'd0;
    b2 = 8'd0;
    b3 = 8'd0;
    case (head.last_idx)
      uue_pkg::LEN1: begin
        b0 = {1'b0, head.cp[6:0]};
      end
      uue_pkg::LEN2: begin
        b0 = uue_pkg::LEAD2 | {3'd0, head.cp[10:6]};
        b1 = uue_pkg::CONT  | {2'd0, head.cp[5:0]};
      end
      uue_pkg::LEN3: begin
        b0 = uue_pkg::LEAD3 | {4'd0, head.cp[15:12]};
        b1 = uue_pkg::CONT  | {2'd0, head.cp[11:6]};
        b2 = uue_pkg::CONT  | {2'd0, head.cp[5:0]};
      end
      uue_pkg::LEN4: begin
        b0 = uue_pkg::LEAD4 | {5'd0, head.cp[20:18]};
        b1 = uue_pkg::CONT  | {2'd0, head.cp[17:12]};
        b2 = uue_pkg::CONT  | {2'd0, head.cp[11:6]};
        b3 = uue_pkg::CONT  | {2'd0, head.cp[5:0]};
      end
      default: begin
        b0 = 8'd0;
      end
    endcase
    case (idx)
      2'd0:    sel_byte = b0;
      2'd1:    sel_byte = b1;
      2'd2:    sel_byte = b2;
      default: sel_byte = b3;
    endcase
  end

  // load a byte when the output register is free or being drained
  assign load      = head_valid && (!obuf_valid || pop);
  assign is_last   = !head.emit || (idx == head.last_idx);
  assign head_done = load && is_last;

  // byte index within the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (load) begin
      obuf_valid <= 1'b1;
    end else if (pop) begin
      obuf_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.emit ? sel_byte : 8'd0;
      byte_valid   <= head.emit;
      run_last     <= is_last;
      string_end   <= is_last && head.ends;
      total_length <= head.total;
    end
  end

  assign empty = !obuf_valid;

endmodule

>>> src/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with string end and length report.
// ----------------------------------------------------------------------------
// Usage:
//   input queue: drive code_unit/final_unit with push; a transfer happens at
//   a clock edge with push high and full low. A zero unit or final_unit ends
//   the string; units after a zero unit are skipped up to the final unit.
//   result queue: while empty is low the oldest result sits on out_byte,
//   byte_valid, run_last, string_end, total_length; pop takes it.
//   config: out_capacity is written at an edge with cfg_valid and cfg_ready
//   (always ready); write it only while the block is idle.
// Path: an item's record is written into the record queue at its input
//   transfer, and its first result is then loaded into the output register.
// Throughput: one output byte per cycle while pop drains the output register;
//   an item gives one to four results (four for a surrogate pair), and input
//   transfers go on every cycle while the four-entry record queue has room.
// Reset: synchronous rst clears the queue, output register, surrogate, skip and
//   count state, and sets the stored capacity to 65535.
// Stall: if pop stays low the output register holds, the record queue fills
//   and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
  parameter int LENGTH_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] out_capacity,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        final_unit,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        string_end,
  output logic [19:0] total_length
);

  logic          in_fire;
  logic          rec_push;
  uue_pkg::rec_t rec;
  uue_pkg::rec_t head;
  logic          head_valid;
  logic          head_done;
  logic          q_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_fire   = push && !q_full;

  // classifier
  uue_front #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .out_capacity (out_capacity),
    .in_fire      (in_fire),
    .code_unit    (code_unit),
    .final_unit   (final_unit),
    .rec_push     (rec_push),
    .rec          (rec)
  );

  // record queue
  uue_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_rec   (rec),
    .rd_en    (head_done),
    .rd_rec   (head),
    .rd_valid (head_valid),
    .q_full   (q_full)
  );

  // serializer
  uue_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_done    (head_done),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .string_end   (string_end),
    .total_length (total_length)
  );

  // a full queue always presents a head record
  assert property (@(posedge clk) disable iff (rst) q_full |-> head_valid)
    else $error("queue full without head record");

  // a bare end marker is always the last result of its item and ends the string
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (run_last && string_end))
    else $error("bare marker without end flags");

  // string end only on the last result of an item
  assert property (@(posedge clk) disable iff (rst)
    (!empty && string_end) |-> run_last)
    else $error("string end before last result");

  // a record leaves the queue only while one is there
  assert property (@(posedge clk) disable iff (rst) head_done |-> head_valid)
    else $error("dequeue from empty queue");

endmodule
